### design/base64_stream_decoder_top_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the base64 stream decoder
// Shorthand for clocked, reset-qualified concurrent assertions.
// ----------------------------------------------------------------------------
`ifndef BASE64_STREAM_DECODER_TOP_MACROS_SVH
`define BASE64_STREAM_DECODER_TOP_MACROS_SVH

// Check a property on every rising edge while reset is released.
`define B64D_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check a property on every rising edge, reset included.
`define B64D_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

### design/b64d_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// b64d_pkg
// Shared types, constants and the alphabet lookup of the base64 decoder.
// ----------------------------------------------------------------------------
package b64d_pkg;

    localparam logic [7:0] PAD_CHAR    = 8'h3D;  // '='
    localparam logic [7:0] PLUS_CHAR   = 8'h2B;  // '+'
    localparam logic [7:0] SLASH_CHAR  = 8'h2F;  // '/'
    localparam int         QUEUE_DEPTH = 2;

    // Bytes per decoded group and their count codes
    localparam logic [1:0] CNT_ONE   = 2'd1;
    localparam logic [1:0] CNT_THREE = 2'd3;

    typedef struct packed {
        logic [7:0] char_in;
        logic       final_char;
    } t_in_item;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
        logic       truncated;
    } t_out_item;

    // One decoded group handed from the front to the back
    typedef struct packed {
        logic [23:0] word;
        logic [1:0]  count;
        logic        last;
        logic        trunc;
    } t_cmd;

    function automatic logic [5:0] char_to_sextet(input logic [7:0] c);
        logic [5:0] sx;
        sx = 6'd0;
        if (c inside {[8'h41:8'h5A]}) begin
            sx = 6'(c - 8'h41);
        end else if (c inside {[8'h61:8'h7A]}) begin
            sx = 6'(c - 8'h61 + 8'd26);
        end else if (c inside {[8'h30:8'h39]}) begin
            sx = 6'(c - 8'h30 + 8'd52);
        end else if (c == PLUS_CHAR) begin
            sx = 6'd62;
        end else if (c == SLASH_CHAR) begin
            sx = 6'd63;
        end
        return sx;
    endfunction

endpackage

### design/b64d_stream_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// b64d_stream_if
// Valid/ready channel carrying one payload item per transaction.
// ----------------------------------------------------------------------------
interface b64d_stream_if #(
    parameter type T = logic
);
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

### design/b64d_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// b64d_front
// Map characters to sextets, gather groups of four and queue group commands.
// ----------------------------------------------------------------------------
module b64d_front (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    output logic            o_ready,
    input  logic [7:0]      i_char_in,
    input  logic            i_final_char,
    input  logic            i_q_full,
    output logic            o_push,
    output b64d_pkg::t_cmd  o_cmd
);

    logic [17:0] r_acc, n_acc;
    logic [1:0]  r_pos, n_pos;
    logic        r_pad_third, n_pad_third;

    logic [5:0]  sx;
    logic        is_pad;
    logic        accept;
    logic [1:0]  drop;

    assign sx      = b64d_pkg::char_to_sextet(i_char_in);
    assign is_pad  = (i_char_in == b64d_pkg::PAD_CHAR);
    assign o_ready = !i_q_full;
    assign accept  = i_valid && o_ready;
    assign drop    = {1'b0, i_final_char && is_pad} + {1'b0, i_final_char && r_pad_third};

    always_comb begin
        n_acc       = r_acc;
        n_pos       = r_pos;
        n_pad_third = r_pad_third;
        o_push      = 1'b0;
        o_cmd       = '0;
        if (accept) begin
            if (r_pos != 2'd3) begin
                if (i_final_char) begin
                    // Short final group: one zero byte flagged as truncated
                    o_push      = 1'b1;
                    o_cmd.count = b64d_pkg::CNT_ONE;
                    o_cmd.last  = 1'b1;
                    o_cmd.trunc = 1'b1;
                    n_acc       = '0;
                    n_pos       = '0;
                    n_pad_third = 1'b0;
                end else begin
                    n_acc = {r_acc[11:0], sx};
                    if (r_pos == 2'd2) begin
                        n_pad_third = is_pad;
                    end
                    n_pos = r_pos + 2'd1;
                end
            end else begin
                o_push      = 1'b1;
                o_cmd.word  = {r_acc, sx};
                o_cmd.count = b64d_pkg::CNT_THREE - drop;
                o_cmd.last  = i_final_char;
                n_acc       = '0;
                n_pos       = '0;
                n_pad_third = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc       <= '0;
            r_pos       <= '0;
            r_pad_third <= 1'b0;
        end else begin
            r_acc       <= n_acc;
            r_pos       <= n_pos;
            r_pad_third <= n_pad_third;
        end
    end

endmodule

### design/b64d_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// b64d_queue
// Small show-ahead queue of group commands between front and back.
// ----------------------------------------------------------------------------
module b64d_queue #(
    parameter int DEPTH = b64d_pkg::QUEUE_DEPTH
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  b64d_pkg::t_cmd  i_cmd,
    output logic            o_full,
    input  logic            i_pop,
    output logic            o_not_empty,
    output b64d_pkg::t_cmd  o_cmd
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    b64d_pkg::t_cmd r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, r_rd_ptr;
    logic [CNT_W-1:0] r_count;

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        return (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
    endfunction

    assign o_full      = (r_count == CNT_W'(DEPTH));
    assign o_not_empty = (r_count != '0);
    assign o_cmd       = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= ptr_inc(r_wr_ptr);
            end
            if (i_pop) begin
                r_rd_ptr <= ptr_inc(r_rd_ptr);
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + CNT_W'(1);
            end else if (!i_push && i_pop) begin
                r_count <= r_count - CNT_W'(1);
            end
        end
    end

endmodule

### design/b64d_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// b64d_back
// Hold one group command and emit its bytes, one per transaction.
// ----------------------------------------------------------------------------
module b64d_back (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_q_not_empty,
    input  b64d_pkg::t_cmd  i_cmd,
    output logic            o_pop,
    output logic            o_valid,
    input  logic            i_ready,
    output logic [7:0]      o_data_byte,
    output logic            o_last_byte,
    output logic            o_truncated
);

    b64d_pkg::t_cmd r_cmd;
    logic        r_busy, n_busy;
    logic [1:0]  r_idx, n_idx;
    logic        end_of_cmd;
    logic        sent;

    assign end_of_cmd = (r_idx == r_cmd.count - 2'd1);
    assign sent       = r_busy && i_ready;
    assign o_pop      = i_q_not_empty && (!r_busy || (sent && end_of_cmd));

    assign o_valid     = r_busy;
    assign o_last_byte = r_cmd.last && end_of_cmd;
    assign o_truncated = r_cmd.trunc;

    always_comb begin
        case (r_idx)
            2'd0:    o_data_byte = r_cmd.word[23:16];
            2'd1:    o_data_byte = r_cmd.word[15:8];
            default: o_data_byte = r_cmd.word[7:0];
        endcase
    end

    always_comb begin
        n_busy = r_busy;
        n_idx  = r_idx;
        if (o_pop) begin
            n_busy = 1'b1;
            n_idx  = '0;
        end else if (sent) begin
            if (end_of_cmd) begin
                n_busy = 1'b0;
            end else begin
                n_idx = r_idx + 2'd1;
            end
        end
    end

    // Payload: load on pop only
    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_cmd <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_idx  <= '0;
        end else begin
            r_busy <= n_busy;
            r_idx  <= n_idx;
        end
    end

endmodule

### design/base64_stream_decoder_top.sv
`timescale 1ns / 1ps
// Path: a group's first byte is written to the queue at the edge that takes its fourth
//   character, then loaded into the output register when the back pops it from the queue.
// Throughput: one character per cycle unless the queue is full; while ready, one byte
//   per cycle, at most one per character, so the queue drains no slower than it fills.
// Reset: i_rst_n is synchronous, active low; it clears group position, queue and output.
// ----------------------------------------------------------------------------
// base64_stream_decoder_top
// Base64 stream decoder: characters in, decoded bytes out, with padding and
// truncation handling on the final group of a string.
// ----------------------------------------------------------------------------
module base64_stream_decoder_top #(
    parameter int QUEUE_DEPTH = b64d_pkg::QUEUE_DEPTH
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    b64d_stream_if.sink   i_in,
    b64d_stream_if.source o_out
);

    // Front to queue
    logic           front_push;
    b64d_pkg::t_cmd front_cmd;
    logic           q_full;

    // Queue to back
    logic           q_not_empty;
    b64d_pkg::t_cmd q_cmd;
    logic           back_pop;

    // Front: decode each character and build one command per group. A final
    // character that closes a short group turns into a one-byte truncation
    // command. Hold input ready low only while the queue is full.
    b64d_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_in.valid),
        .o_ready      (i_in.ready),
        .i_char_in    (i_in.data.char_in),
        .i_final_char (i_in.data.final_char),
        .i_q_full     (q_full),
        .o_push       (front_push),
        .o_cmd        (front_cmd)
    );

    // Queue: decouple the front from output backpressure so character
    // transactions keep flowing while a decoded byte waits to be taken.
    b64d_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (front_push),
        .i_cmd       (front_cmd),
        .o_full      (q_full),
        .i_pop       (back_pop),
        .o_not_empty (q_not_empty),
        .o_cmd       (q_cmd)
    );

    // Back: serialize each command into byte transactions, most significant
    // byte first; advance to the next command in the same cycle the last
    // byte of the current one is taken.
    b64d_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_q_not_empty (q_not_empty),
        .i_cmd         (q_cmd),
        .o_pop         (back_pop),
        .o_valid       (o_out.valid),
        .i_ready       (o_out.ready),
        .o_data_byte   (o_out.data.data_byte),
        .o_last_byte   (o_out.data.last_byte),
        .o_truncated   (o_out.data.truncated)
    );

endmodule

### design/b64d_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// b64d_checker
// Port-level checks on the decoder's output channel, bound to the top level.
// ----------------------------------------------------------------------------
`include "base64_stream_decoder_top_macros.svh"

module b64d_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_out_valid,
    input logic       i_out_ready,
    input logic [7:0] i_data_byte,
    input logic       i_last_byte,
    input logic       i_truncated
);

    // A truncation transaction is the zero byte that closes the string
    `B64D_ASSERT(a_trunc_is_last, i_clk, i_rst_n, (i_out_valid && i_truncated) |-> (i_last_byte && (i_data_byte == 8'd0)), "truncation result malformed")

    // A stalled output transaction holds its payload
    `B64D_ASSERT(a_out_hold, i_clk, i_rst_n, (i_out_valid && !i_out_ready) |=> (i_out_valid && $stable(i_data_byte) && $stable(i_last_byte) && $stable(i_truncated)), "stalled output changed")

    // No output directly after reset is released
    `B64D_ASSERT_ALWAYS(a_idle_after_reset, i_clk, $rose(i_rst_n) |-> !i_out_valid, "output valid after reset")

endmodule

bind base64_stream_decoder_top b64d_checker u_b64d_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_data_byte (o_out.data.data_byte),
    .i_last_byte (o_out.data.last_byte),
    .i_truncated (o_out.data.truncated)
);

### tb/sv/base64_stream_decoder_top_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// base64_stream_decoder_top_test
// Self-checking bench for the base64 stream decoder. A scoreboard class
// decodes every accepted character on its own and queues the bytes it
// expects; each byte taken from the output is checked against the oldest
// one. Directed strings cover padding, truncation and the alphabet edges,
// then random strings (clean, padded, broken, short and pure noise) follow, with
// random gaps on the character side and random stalls on the byte side.
// ----------------------------------------------------------------------------
module base64_stream_decoder_top_test;

    localparam int CLK_PERIOD   = 10;
    localparam int RESET_CYCLES = 10;
    localparam int RANDOM_CHARS = 270;
    localparam int DRAIN_CYCLES = 40;
    // Worst case is roughly a maximal gap before every character and every byte,
    // for about 300 characters; allow several times that.
    localparam int CYCLE_LIMIT  = 200000;
    localparam int MAX_GAP      = 18;

    // ------------------------------------------------------------------------
    // Scoreboard: mirror the decoder state and hold the bytes still owed
    // ------------------------------------------------------------------------
    class b64_scoreboard;
        logic [17:0]         sextet_acc;
        logic [1:0]          group_pos;
        logic                pad_third;
        b64d_pkg::t_out_item expected_bytes[$];
        int unsigned         mismatch_count;

        function new();
            clear_group();
            mismatch_count = 0;
        endfunction

        function void clear_group();
            sextet_acc = '0;
            group_pos  = '0;
            pad_third  = 1'b0;
        endfunction

        function logic [5:0] sextet_of(input logic [7:0] c);
            if (c >= "A" && c <= "Z") return 6'(c - "A");
            if (c >= "a" && c <= "z") return 6'(c - "a" + 26);
            if (c >= "0" && c <= "9") return 6'(c - "0" + 52);
            if (c == b64d_pkg::PLUS_CHAR) return 6'd62;
            if (c == b64d_pkg::SLASH_CHAR) return 6'd63;
            return 6'd0;
        endfunction

        // Decode one accepted character and queue the bytes it releases.
        function void note_char(input b64d_pkg::t_in_item item);
            logic [5:0]          sx;
            logic [23:0]         word;
            int                  count;
            b64d_pkg::t_out_item b;
            sx = sextet_of(item.char_in);
            if (group_pos != 2'd3) begin
                if (item.final_char) begin
                    // String ended mid-group: one truncation marker
                    b.data_byte = 8'd0;
                    b.last_byte = 1'b1;
                    b.truncated = 1'b1;
                    expected_bytes.push_back(b);
                    clear_group();
                    return;
                end
                sextet_acc = {sextet_acc[11:0], sx};
                if (group_pos == 2'd2) pad_third = (item.char_in == b64d_pkg::PAD_CHAR);
                group_pos = group_pos + 2'd1;
                return;
            end
            word  = {sextet_acc, sx};
            count = 3;
            if (item.final_char) begin
                if (item.char_in == b64d_pkg::PAD_CHAR) count--;
                if (pad_third) count--;
            end
            for (int k = 0; k < count; k++) begin
                b.data_byte = word[23 - 8 * k -: 8];
                b.last_byte = item.final_char && (k + 1 == count);
                b.truncated = 1'b0;
                expected_bytes.push_back(b);
            end
            clear_group();
        endfunction

        // Compare one accepted byte with the oldest expectation.
        function void check_byte(input b64d_pkg::t_out_item got);
            b64d_pkg::t_out_item want;
            if (expected_bytes.size() == 0) begin
                $error("unexpected byte: data_byte %02h last_byte %0b truncated %0b",
                       got.data_byte, got.last_byte, got.truncated);
                mismatch_count++;
                return;
            end
            want = expected_bytes.pop_front();
            if (got.data_byte !== want.data_byte) begin
                $error("data_byte: expected %02h, got %02h", want.data_byte, got.data_byte);
                mismatch_count++;
            end
            if (got.last_byte !== want.last_byte) begin
                $error("last_byte: expected %0b, got %0b", want.last_byte, got.last_byte);
                mismatch_count++;
            end
            if (got.truncated !== want.truncated) begin
                $error("truncated: expected %0b, got %0b", want.truncated, got.truncated);
                mismatch_count++;
            end
        endfunction

        function int unsigned pending();
            return expected_bytes.size();
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // Clock, reset, channels and the block under test
    // ------------------------------------------------------------------------
    logic i_clk = 1'b0;
    logic i_rst_n;

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    b64d_stream_if #(.T(b64d_pkg::t_in_item))  char_chan ();
    b64d_stream_if #(.T(b64d_pkg::t_out_item)) byte_chan ();

    base64_stream_decoder_top DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (char_chan),
        .o_out   (byte_chan)
    );

    b64_scoreboard sb = new();

    int unsigned chars_sent = 0;
    int unsigned cycle_count = 0;
    bit          char_quiet = 1'b0;  // no gaps on the character side
    bit          byte_quiet = 1'b0;  // no stalls on the byte side

    // Draw the idle cycles before the next transaction on one side.
    function automatic int unsigned idle_gap(input bit quiet);
        return quiet ? 0 : $urandom_range(0, MAX_GAP);
    endfunction

    // Map an index to its character in the standard alphabet.
    function automatic logic [7:0] b64_symbol(input logic [5:0] idx);
        if (idx < 26) return 8'("A" + idx);
        if (idx < 52) return 8'("a" + idx - 26);
        if (idx < 62) return 8'("0" + idx - 52);
        return (idx == 62) ? b64d_pkg::PLUS_CHAR : b64d_pkg::SLASH_CHAR;
    endfunction

    // ------------------------------------------------------------------------
    // Monitors: sample both channels at the edge, before any new drive lands
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (i_rst_n === 1'b1 && char_chan.valid && char_chan.ready) begin
            sb.note_char(char_chan.data);
        end
        if (i_rst_n === 1'b1 && byte_chan.valid && byte_chan.ready) begin
            sb.check_byte(byte_chan.data);
        end
    end

    // Abort a hung run.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("base64_stream_decoder_top_test NOT OK");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Byte side: stall a random number of cycles, then hold ready until a
    // transaction completes; now and then flip into or out of a quiet stretch
    // ------------------------------------------------------------------------
    initial begin
        int unsigned gap;
        forever begin
            if ($urandom_range(0, 15) == 0) byte_quiet = ~byte_quiet;
            gap = idle_gap(byte_quiet);
            if (gap != 0) begin
                byte_chan.ready <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            byte_chan.ready <= 1'b1;
            do @(posedge i_clk); while (!(byte_chan.valid && i_rst_n === 1'b1));
        end
    end

    // ------------------------------------------------------------------------
    // Character side
    // ------------------------------------------------------------------------
    // Offer one character after a random gap and hold it until accepted.
    // Valid stays high on acceptance; the next call lowers it only when it
    // idles, so valid never sees two assignments in one step.
    task automatic send_char(input logic [7:0] c, input logic fin);
        int unsigned gap;
        gap = idle_gap(char_quiet);
        if (gap != 0) begin
            char_chan.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        char_chan.valid <= 1'b1;
        char_chan.data  <= b64d_pkg::t_in_item'{char_in: c, final_char: fin};
        do @(posedge i_clk); while (!char_chan.ready);
        chars_sent++;
    endtask

    // Send a whole string, flagging its last character as final.
    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++) send_char(s[i], i == s.len() - 1);
    endtask

    initial begin
        logic [7:0]  text[$];
        int unsigned kind;
        int unsigned groups;
        int unsigned pads;
        int unsigned start;
        int unsigned len;
        logic [7:0]  c;

        i_rst_n         <= 1'b0;
        char_chan.valid <= 1'b0;
        char_chan.data  <= '0;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed strings: a plain group, both pad counts, pads inside the
        // string and in the leading positions, then short final groups.
        send_text("TWFu");
        send_text("QQ==");
        send_text("QUI=");
        send_text("A=z=0+/9");
        send_char("Z", 1'b1);
        send_char(8'hFF, 1'b0);
        send_char(8'h00, 1'b0);
        send_char("~", 1'b1);

        // Random strings, mostly well formed so that full groups decode.
        start = chars_sent;
        while (chars_sent - start < RANDOM_CHARS) begin
            char_quiet = ($urandom_range(0, 3) == 0);
            kind       = $urandom_range(0, 9);
            text.delete();
            if (kind == 9) begin
                // Noise: any byte, final flag anywhere
                len = $urandom_range(1, 12);
                for (int i = 0; i < len; i++) begin
                    send_char(8'($urandom_range(0, 255)),
                              (i == len - 1) || ($urandom_range(0, 7) == 0));
                end
            end else begin
                groups = $urandom_range(1, 3);
                pads   = $urandom_range(0, 2);
                for (int g = 0; g < groups; g++) begin
                    for (int p = 0; p < 4; p++) begin
                        c = b64_symbol(6'($urandom_range(0, 63)));
                        // Broken content: stray pads and unknown bytes
                        if (kind >= 6 && kind <= 7) begin
                            if ($urandom_range(0, 4) == 0) c = b64d_pkg::PAD_CHAR;
                            else if ($urandom_range(0, 6) == 0) c = 8'($urandom_range(0, 255));
                        end
                        if (g == groups - 1 && p == 3 && pads >= 1) c = b64d_pkg::PAD_CHAR;
                        if (g == groups - 1 && p == 2 && pads == 2) c = b64d_pkg::PAD_CHAR;
                        text.push_back(c);
                    end
                end
                // Short final group: append one to three characters
                if (kind == 8) begin
                    len = $urandom_range(1, 3);
                    repeat (len) text.push_back(b64_symbol(6'($urandom_range(0, 63))));
                end
                foreach (text[i]) send_char(text[i], i == text.size() - 1);
            end
        end
        char_chan.valid <= 1'b0;

        // Drain: wait for every owed byte, then watch a while for extras.
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (sb.mismatch_count == 0) begin
            $display("base64_stream_decoder_top_test OK");
        end else begin
            $display("base64_stream_decoder_top_test NOT OK");
        end
        $finish;
    end

endmodule

### base64_stream_decoder_top.f
+incdir+design
design/b64d_pkg.sv
design/b64d_stream_if.sv
design/b64d_front.sv
design/b64d_queue.sv
design/b64d_back.sv
design/base64_stream_decoder_top.sv
design/b64d_checker.sv
tb/sv/base64_stream_decoder_top_test.sv
